// ----- hdl/mi3_pkg.sv -----
// mi3_pkg: types, widths and helper functions shared by the 3x3 matrix inverse
// block. No dependencies; every other file in hdl/ imports this package.
package mi3_pkg;

  // element format and derived widths
  localparam int ELEM_W = 32;                 // signed element width
  localparam int FRAC_W = 16;                 // fraction bits
  localparam int THR_W  = 31;                 // threshold register width
  localparam int PROD_W = 2 * ELEM_W;         // element x element
  localparam int COF_W  = PROD_W + 1;         // difference of two products
  localparam int HI_W   = COF_W - ELEM_W;     // upper slice of a cofactor
  localparam int PP_W   = 2 * ELEM_W + 1;     // element x cofactor slice
  localparam int DET_W  = 3 * ELEM_W + 3;     // determinant, signed
  localparam int REM_W  = DET_W + ELEM_W;     // divider working width
  localparam int NUM_W  = COF_W + 2 * FRAC_W; // cofactor magnitude, scaled
  localparam int N_EL   = 9;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [COF_W-1:0]  cof_t;
  typedef logic signed [PP_W-1:0]   pp_t;
  typedef logic signed [DET_W-1:0]  det_t;
  typedef logic [DET_W-1:0]         dmag_t;
  typedef logic [REM_W-1:0]         rem_t;
  typedef logic [ELEM_W-1:0]        quo_t;
  typedef logic [THR_W-1:0]         thr_t;

  typedef struct packed {
    elem_t m00; elem_t m01; elem_t m02;
    elem_t m10; elem_t m11; elem_t m12;
    elem_t m20; elem_t m21; elem_t m22;
  } in_item_t;

  typedef struct packed {
    elem_t r00; elem_t r01; elem_t r02;
    elem_t r10; elem_t r11; elem_t r12;
    elem_t r20; elem_t r21; elem_t r22;
    logic  invertible;
  } out_item_t;

  // cofactor i = s[CF_A]*s[CF_B] - s[CF_C]*s[CF_D], already in adjugate order
  localparam int CF_A [N_EL] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int CF_B [N_EL] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int CF_C [N_EL] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int CF_D [N_EL] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  // signed saturating result from quotient magnitude
  function automatic elem_t sat_elem(quo_t q, logic big, logic neg);
    quo_t half;
    quo_t maxp;
    half = {1'b1, {(ELEM_W-1){1'b0}}};
    maxp = {1'b0, {(ELEM_W-1){1'b1}}};
    if (neg) begin
      if (big || q > half) return elem_t'(half);
      return elem_t'(quo_t'(-q));
    end
    if (big || q > maxp) return elem_t'(maxp);
    return elem_t'(q);
  endfunction

endpackage

// ----- hdl/matrix3x3_inverse.sv -----
// matrix3x3_inverse: top level of the pipelined 3x3 matrix inverse.
// Depends on mi3_pkg, mi3_cofactor, mi3_det and mi3_div.
//
// One signed Q16.16 3x3 matrix enters per cycle and one result leaves per
// cycle while neither side stalls, through 2 cofactor stages, 3 determinant
// stages, one singular-test stage, one overflow stage, 32 quotient-bit stages
// and the output register; the quotient-bit stages of the nine restoring
// dividers make up most of the pipeline depth. The result is the adjugate
// divided by the determinant, truncated toward zero and saturated to the
// Q16.16 limits, with invertible set, when |det| is above det_threshold;
// otherwise the input matrix comes back unchanged with invertible clear. The
// whole pipeline advances as one; a skid register behind the output register
// takes a result that arrives while the output register waits on out_stall,
// and in_stall follows that skid register, so the input side stalls while the
// output holds a waiting result with another one behind it.
// cfg_ready is always high; write det_threshold only while the pipe is empty.
module matrix3x3_inverse (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  mi3_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mi3_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  mi3_pkg::thr_t      cfg_data
);
  import mi3_pkg::*;

  // threshold register
  thr_t      det_threshold;

  // pipeline enable, frozen while the skid register holds a result
  logic      en;

  // stage links
  logic      cf_valid;
  cof_t      cf_cof [N_EL];
  in_item_t  cf_item;
  logic      dt_valid;
  det_t      dt_det;
  cof_t      dt_cof [N_EL];
  in_item_t  dt_item;
  logic      dv_valid;
  quo_t      dv_q [N_EL];
  logic      dv_big [N_EL];
  logic      dv_neg [N_EL];
  logic      dv_inv;
  in_item_t  dv_item;

  // output assembly
  elem_t     res [N_EL];
  out_item_t res_item;

  // skid register
  logic      skid_valid;
  out_item_t skid_data;
  logic      out_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) det_threshold <= thr_t'(1);
    else if (cfg_valid && cfg_ready) det_threshold <= cfg_data;
  end

  assign en       = !skid_valid;
  assign in_stall = skid_valid;

  mi3_cofactor u_cofactor (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .in_item   (in_data),
    .out_valid (cf_valid),
    .cof       (cf_cof),
    .item      (cf_item)
  );

  mi3_det u_det (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cf_valid),
    .in_cof    (cf_cof),
    .in_item   (cf_item),
    .out_valid (dt_valid),
    .det       (dt_det),
    .cof       (dt_cof),
    .item      (dt_item)
  );

  mi3_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .thr       (det_threshold),
    .in_valid  (dt_valid),
    .in_det    (dt_det),
    .in_cof    (dt_cof),
    .in_item   (dt_item),
    .out_valid (dv_valid),
    .q         (dv_q),
    .big       (dv_big),
    .neg       (dv_neg),
    .inv       (dv_inv),
    .item      (dv_item)
  );

  // saturate quotients, or pass the matrix through when singular
  always_comb begin
    for (int i = 0; i < N_EL; i++) res[i] = sat_elem(dv_q[i], dv_big[i], dv_neg[i]);
    if (dv_inv) begin
      res_item = '{r00: res[0], r01: res[1], r02: res[2],
                   r10: res[3], r11: res[4], r12: res[5],
                   r20: res[6], r21: res[7], r22: res[8],
                   invertible: 1'b1};
    end else begin
      res_item = '{r00: dv_item.m00, r01: dv_item.m01, r02: dv_item.m02,
                   r10: dv_item.m10, r11: dv_item.m11, r12: dv_item.m12,
                   r20: dv_item.m20, r21: dv_item.m21, r22: dv_item.m22,
                   invertible: 1'b0};
    end
  end

  // output register plus skid register
  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // pipe frozen, drain skid into the output register on transfer
      if (out_take) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || out_take) begin
      out_valid <= dv_valid;
    end else if (dv_valid) begin
      // output held, park the arriving result
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) out_data <= skid_data;
    end else if (!out_valid || out_take) begin
      out_data <= res_item;
    end else if (dv_valid) begin
      skid_data <= res_item;
    end
  end

  // skid is only ever occupied behind a waiting result
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a result while output register is empty");

  // skid only fills from a stalled, full output register
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && out_stall))
    else $error("skid filled without a stalled output");

  // a parked result stays put while the output stays stalled
  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    skid_valid && out_stall |=> skid_valid && $stable(skid_data))
    else $error("skid result lost during stall");

endmodule

// ----- hdl/mi3_cofactor.sv -----
// mi3_cofactor: two register stages, eighteen element products then the nine
// cofactors of the adjugate. Depends on mi3_pkg.
module mi3_cofactor (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  mi3_pkg::in_item_t in_item,
  output logic              out_valid,
  output mi3_pkg::cof_t     cof [9],
  output mi3_pkg::in_item_t item
);
  import mi3_pkg::*;

  elem_t    s [N_EL];
  logic     v1;
  prod_t    pa [N_EL];
  prod_t    pb [N_EL];
  in_item_t item1;

  always_comb begin
    s[0] = in_item.m00; s[1] = in_item.m01; s[2] = in_item.m02;
    s[3] = in_item.m10; s[4] = in_item.m11; s[5] = in_item.m12;
    s[6] = in_item.m20; s[7] = in_item.m21; s[8] = in_item.m22;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N_EL; i++) begin
        pa[i]  <= s[CF_A[i]] * s[CF_B[i]];
        pb[i]  <= s[CF_C[i]] * s[CF_D[i]];
        cof[i] <= cof_t'(pa[i]) - cof_t'(pb[i]);
      end
      item1 <= in_item;
      item  <= item1;
    end
  end

endmodule

// ----- hdl/mi3_det.sv -----
// mi3_det: determinant by first-row expansion in three register stages,
// split products, per-row sums, final sum. Depends on mi3_pkg.
module mi3_det (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  mi3_pkg::cof_t     in_cof [9],
  input  mi3_pkg::in_item_t in_item,
  output logic              out_valid,
  output mi3_pkg::det_t     det,
  output mi3_pkg::cof_t     cof [9],
  output mi3_pkg::in_item_t item
);
  import mi3_pkg::*;

  elem_t    row0 [3];
  logic     v1;
  logic     v2;
  pp_t      lo [3];
  pp_t      hi [3];
  det_t     rsum [3];
  cof_t     cof1 [N_EL];
  cof_t     cof2 [N_EL];
  in_item_t item1;
  in_item_t item2;

  assign row0[0] = in_item.m00;
  assign row0[1] = in_item.m01;
  assign row0[2] = in_item.m02;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        // cofactor split into unsigned low word and signed high slice
        lo[r]   <= row0[r] * $signed({1'b0, in_cof[3*r][ELEM_W-1:0]});
        hi[r]   <= row0[r] * $signed(in_cof[3*r][COF_W-1:ELEM_W]);
        rsum[r] <= (det_t'(hi[r]) <<< ELEM_W) + det_t'(lo[r]);
      end
      det   <= rsum[0] + rsum[1] + rsum[2];
      cof1  <= in_cof;
      cof2  <= cof1;
      cof   <= cof2;
      item1 <= in_item;
      item2 <= item1;
      item  <= item2;
    end
  end

endmodule

// ----- hdl/mi3_div.sv -----
// mi3_div: singular test plus nine restoring dividers, one quotient bit per
// register stage, with an overflow stage in front. Depends on mi3_pkg.
module mi3_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  mi3_pkg::thr_t     thr,
  input  logic              in_valid,
  input  mi3_pkg::det_t     in_det,
  input  mi3_pkg::cof_t     in_cof [9],
  input  mi3_pkg::in_item_t in_item,
  output logic              out_valid,
  output mi3_pkg::quo_t     q [9],
  output logic              big [9],
  output logic              neg [9],
  output logic              inv,
  output mi3_pkg::in_item_t item
);
  import mi3_pkg::*;

  localparam int N_ST = ELEM_W + 2;

  logic     v_st    [N_ST];
  dmag_t    dm_st   [N_ST];
  rem_t     rem_st  [N_ST][N_EL];
  quo_t     q_st    [N_ST][N_EL];
  logic     big_st  [N_ST][N_EL];
  logic     neg_st  [N_ST][N_EL];
  logic     inv_st  [N_ST];
  in_item_t item_st [N_ST];

  dmag_t    dmag_in;
  dmag_t    thr_scaled;

  assign dmag_in    = in_det[DET_W-1] ? dmag_t'(-in_det) : dmag_t'(in_det);
  assign thr_scaled = dmag_t'({thr, {(2*FRAC_W){1'b0}}});

  // prep stage: magnitudes, signs, singular test
  always_ff @(posedge clk) begin
    if (rst) v_st[0] <= 1'b0;
    else if (en) v_st[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dm_st[0]   <= dmag_in;
      inv_st[0]  <= dmag_in > thr_scaled;
      item_st[0] <= in_item;
      for (int i = 0; i < N_EL; i++) begin
        rem_st[0][i] <= rem_t'({(in_cof[i][COF_W-1] ? cof_t'(-in_cof[i]) : in_cof[i]),
                                {(2*FRAC_W){1'b0}}});
        q_st[0][i]   <= '0;
        big_st[0][i] <= 1'b0;
        neg_st[0][i] <= in_cof[i][COF_W-1] ^ in_det[DET_W-1];
      end
    end
  end

  for (genvar j = 1; j < N_ST; j++) begin : g_st
    localparam int K = N_ST - 1 - j;

    always_ff @(posedge clk) begin
      if (rst) v_st[j] <= 1'b0;
      else if (en) v_st[j] <= v_st[j-1];
    end

    if (j == 1) begin : g_ovf
      // quotient of 2^ELEM_W or more saturates regardless of low bits
      always_ff @(posedge clk) begin
        if (en) begin
          for (int i = 0; i < N_EL; i++) begin
            big_st[j][i] <= rem_st[j-1][i] >= (rem_t'(dm_st[j-1]) << K);
            rem_st[j][i] <= rem_st[j-1][i];
            q_st[j][i]   <= q_st[j-1][i];
          end
        end
      end
    end else begin : g_bit
      always_ff @(posedge clk) begin
        if (en) begin
          for (int i = 0; i < N_EL; i++) begin
            big_st[j][i] <= big_st[j-1][i];
            if (rem_st[j-1][i] >= (rem_t'(dm_st[j-1]) << K)) begin
              rem_st[j][i] <= rem_st[j-1][i] - (rem_t'(dm_st[j-1]) << K);
              q_st[j][i]   <= q_st[j-1][i] | (quo_t'(1'b1) << K);
            end else begin
              rem_st[j][i] <= rem_st[j-1][i];
              q_st[j][i]   <= q_st[j-1][i];
            end
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dm_st[j]   <= dm_st[j-1];
        inv_st[j]  <= inv_st[j-1];
        item_st[j] <= item_st[j-1];
        for (int i = 0; i < N_EL; i++) neg_st[j][i] <= neg_st[j-1][i];
      end
    end
  end

  assign out_valid = v_st[N_ST-1];
  assign inv       = inv_st[N_ST-1];
  assign item      = item_st[N_ST-1];
  always_comb begin
    for (int i = 0; i < N_EL; i++) begin
      q[i]   = q_st[N_ST-1][i];
      big[i] = big_st[N_ST-1][i];
      neg[i] = neg_st[N_ST-1][i];
    end
  end

endmodule

// ----- tb/tb_matrix3x3_inverse.sv -----
// tb_matrix3x3_inverse: self-checking bench for the pipelined 3x3 matrix inverse.
// Depends on mi3_pkg and matrix3x3_inverse; holds its own adjugate/divide predictor.
module tb_matrix3x3_inverse;
  timeunit 1ns;
  timeprecision 1ps;
  import mi3_pkg::*;

  localparam int N_DIRECTED = 20;
  localparam int N_RANDOM   = 450;
  localparam int DRAIN_CYC  = 60;     // covers the pipe depth, plus margin
  localparam int HOLD_CYC   = 150;    // long receiver hold-off

  typedef logic signed [255:0] wide_t;

  // inverse predictor: exact cofactors and determinant, truncating divide, saturation
  function automatic out_item_t predict_inverse(in_item_t mat, logic [30:0] thr);
    wide_t s [9];
    wide_t c [9];
    wide_t det, adet, thr_w, num, q;
    logic neg;
    out_item_t res;
    elem_t r [9];
    s[0] = mat.m00; s[1] = mat.m01; s[2] = mat.m02;
    s[3] = mat.m10; s[4] = mat.m11; s[5] = mat.m12;
    s[6] = mat.m20; s[7] = mat.m21; s[8] = mat.m22;
    c[0] = s[4]*s[8] - s[5]*s[7];
    c[1] = s[2]*s[7] - s[1]*s[8];
    c[2] = s[1]*s[5] - s[2]*s[4];
    c[3] = s[5]*s[6] - s[3]*s[8];
    c[4] = s[0]*s[8] - s[2]*s[6];
    c[5] = s[2]*s[3] - s[0]*s[5];
    c[6] = s[3]*s[7] - s[4]*s[6];
    c[7] = s[1]*s[6] - s[0]*s[7];
    c[8] = s[0]*s[4] - s[1]*s[3];
    det = s[0]*c[0] + s[1]*c[3] + s[2]*c[6];
    adet = det < 0 ? -det : det;
    thr_w = wide_t'({1'b0, thr}) <<< (2*FRAC_W);
    if (adet > thr_w) begin
      for (int i = 0; i < 9; i++) begin
        neg = (c[i] < 0) != (det < 0);
        num = c[i] < 0 ? -c[i] : c[i];
        q = (num <<< (2*FRAC_W)) / adet;
        if (neg) r[i] = (q > 64'sh8000_0000) ? elem_t'(32'h8000_0000) : elem_t'(-q);
        else r[i] = (q > 64'sh7fff_ffff) ? elem_t'(32'h7fff_ffff) : elem_t'(q);
      end
      res.invertible = 1'b1;
    end else begin
      for (int i = 0; i < 9; i++) r[i] = s[i][31:0];
      res.invertible = 1'b0;
    end
    {res.r00, res.r01, res.r02, res.r10, res.r11, res.r12, res.r20, res.r21, res.r22} =
      {r[0], r[1], r[2], r[3], r[4], r[5], r[6], r[7], r[8]};
    return res;
  endfunction

  // scoreboard: queue of expected inverses, checked in order
  class inverse_scoreboard;
    out_item_t pending_inv [$];
    int n_err;
    int n_inv;
    int n_sing;

    function void note_matrix(in_item_t mat, logic [30:0] thr);
      pending_inv.push_back(predict_inverse(mat, thr));
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      elem_t e [9];
      elem_t g [9];
      if (pending_inv.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        n_err++;
        return;
      end
      exp_r = pending_inv.pop_front();
      if (exp_r.invertible) n_inv++; else n_sing++;
      e = '{exp_r.r00, exp_r.r01, exp_r.r02, exp_r.r10, exp_r.r11, exp_r.r12,
            exp_r.r20, exp_r.r21, exp_r.r22};
      g = '{got.r00, got.r01, got.r02, got.r10, got.r11, got.r12,
            got.r20, got.r21, got.r22};
      for (int i = 0; i < 9; i++)
        if (e[i] !== g[i]) begin
          $display("%0t: r%0d%0d expected %h actual %h", $realtime, i/3, i%3, e[i], g[i]);
          n_err++;
        end
      if (exp_r.invertible !== got.invertible) begin
        $display("%0t: invertible expected %b actual %b", $realtime,
                 exp_r.invertible, got.invertible);
        n_err++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  in_item_t in_data;
  out_item_t out_data;
  thr_t cfg_data;

  inverse_scoreboard sb;
  logic [30:0] cur_thr;     // threshold the block currently holds
  bit hold_req;             // asks the receiver for a long hold-off
  bit stall_mode;           // alternates between stall patterns

  matrix3x3_inverse u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

  // every accepted result goes to the scoreboard
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  // receiver stall pattern, with an occasional long hold-off
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYC) @(negedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (stall_mode) begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_threshold(logic [30:0] thr);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= thr;
    do @(posedge clk); while (!cfg_ready);
    cur_thr = thr;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // offer one matrix and hold it until the transfer happens
  task automatic send_matrix(in_item_t mat);
    in_valid <= 1'b1;
    in_data  <= mat;
    do @(posedge clk); while (in_stall);
    sb.note_matrix(mat, cur_thr);
    @(negedge clk);
  endtask

  task automatic idle_input(int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // wait for every expected inverse, then let the pipe settle
  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (sb.pending_inv.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  function automatic elem_t rand_elem();
    case ($urandom_range(0, 9))
      0: return elem_t'($urandom());
      1: return elem_t'(32'h7fff_ffff);
      2: return elem_t'(32'h8000_0000);
      3: return elem_t'(0);
      4, 5: return elem_t'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
      default: return elem_t'($signed($urandom_range(0, 32'h7ffff)) - 32'sh40000);
    endcase
  endfunction

  function automatic in_item_t rand_matrix();
    in_item_t mat;
    elem_t k;
    mat = {rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
           rand_elem(), rand_elem(), rand_elem(), rand_elem()};
    // sometimes force a singular matrix: row 2 = row 0
    if ($urandom_range(0, 7) == 0) begin
      mat.m20 = mat.m00; mat.m21 = mat.m01; mat.m22 = mat.m02;
    end
    // sometimes a scaled identity, reaching saturation for tiny diagonals
    if ($urandom_range(0, 9) == 0) begin
      k = elem_t'($urandom_range(1, 32'h30000));
      mat = '0;
      mat.m00 = k; mat.m11 = k; mat.m22 = ($urandom_range(0, 1)) ? k : -k;
    end
    return mat;
  endfunction

  function automatic in_item_t diag_matrix(elem_t a, elem_t b, elem_t c);
    in_item_t mat;
    mat = '0;
    mat.m00 = a; mat.m11 = b; mat.m22 = c;
    return mat;
  endfunction

  localparam elem_t ONE = 32'sh0001_0000;
  localparam elem_t MAXE = 32'sh7fff_ffff;
  localparam elem_t MINE = 32'h8000_0000;

  initial begin
    logic [30:0] thr_set [5];
    int sent;
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    hold_req = 1'b0;
    stall_mode = 1'b0;
    cur_thr = 31'd1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: identity, extremes, singular and saturating cases at reset threshold
    send_matrix(diag_matrix(ONE, ONE, ONE));
    send_matrix(diag_matrix(ONE <<< 1, -ONE, ONE >>> 1));
    send_matrix('0);
    send_matrix({9{MAXE}});
    send_matrix({9{MINE}});
    send_matrix(diag_matrix(MAXE, MAXE, MAXE));
    send_matrix(diag_matrix(MINE, MINE, MINE));
    send_matrix(diag_matrix(MINE, MAXE, MINE));
    send_matrix(diag_matrix(32'sd1, 32'sd1, 32'sd1));        // det tiny: singular
    send_matrix(diag_matrix(32'sh100, ONE, ONE));            // large inverse, no saturation
    send_matrix(diag_matrix(-32'sh100, ONE, ONE));           // large negative inverse, no saturation
    send_matrix(diag_matrix(ONE, ONE, 32'sd1));              // det right at the edge
    send_matrix({MAXE, MINE, ONE, -ONE, MAXE, 32'sd0, ONE, MINE, MAXE});
    send_matrix({ONE, ONE <<< 1, ONE * 3, ONE * 4, ONE * 5, ONE * 6,
                 ONE * 7, ONE * 8, ONE * 10});
    send_matrix({32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f,
                 32'hf0f0_f0f0, 32'h1234_5678, 32'hedcb_a987, 32'h0000_0001, 32'h8000_0001});
    drain_pipe();

    // threshold extremes: zero and all ones
    write_threshold(31'd0);
    send_matrix(diag_matrix(32'sd1, 32'sd1, 32'sd1));        // any nonzero det passes
    send_matrix('0);
    send_matrix(diag_matrix(ONE, ONE, ONE));
    drain_pipe();
    write_threshold(31'h7fff_ffff);
    send_matrix(diag_matrix(MAXE, MAXE, MAXE));
    send_matrix(diag_matrix(MINE, MINE, MINE));
    drain_pipe();

    // random phases under several thresholds, bursts and gaps on the input
    thr_set = '{31'd0, 31'd1, 31'h0000_ffff, 31'h7fff_ffff, 31'($urandom())};
    sent = 0;
    for (int ph = 0; ph < 5; ph++) begin
      write_threshold(thr_set[ph]);
      stall_mode = ph[0];
      for (int n = 0; n < N_RANDOM / 5; n++) begin
        if (ph == 2 && n == 10) hold_req = 1'b1;   // back up the whole pipe
        if (ph != 1 && $urandom_range(0, 5) == 0) idle_input($urandom_range(1, 6));
        send_matrix(rand_matrix());
        sent++;
      end
      drain_pipe();
    end

    $display("covered %0d random matrices over 5 thresholds plus directed extremes",
             sent);
    $display("results: %0d invertible, %0d singular, %0d mismatches",
             sb.n_inv, sb.n_sing, sb.n_err);
    if (sb.n_err == 0 && sb.pending_inv.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
